// ===== hw/rtl/sfd_pkg.sv =====
// Package of the SBUS frame decoder: widths, frame constants, codes and command types.
package sfd_pkg;

   localparam int unsigned FRAME_BYTES      = 25;
   localparam int unsigned FRAME_BITS       = 8 * FRAME_BYTES;
   localparam int unsigned NUM_CHANNELS     = 16;
   localparam int unsigned CHAN_BITS        = 11;
   localparam int unsigned CHAN_INDEX_WIDTH = 4;
   localparam int unsigned COUNT_WIDTH      = 5;
   localparam int unsigned CFG_WIDTH        = 10;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;

   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE   = 8'h00;
   localparam logic [7:0] FLAGS_OK   = 8'h00;

   localparam logic [CFG_WIDTH-1:0] DEADBAND_RESET  = 10'd10;
   localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 10'd500;

   localparam logic [COUNT_WIDTH-1:0] FRAME_LEN_COUNT = 5'd25;
   localparam logic [COUNT_WIDTH-1:0] SHORT_LIMIT     = 5'd24;
   localparam logic [CHAN_INDEX_WIDTH-1:0] LAST_CHANNEL = 4'd15;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEADBAND  = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_index_type;

   // frame status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_START = 3'd2,
      ST_FLAGS     = 3'd3,
      ST_BAD_END   = 3'd4
   } frame_status_type;

   // switch position codes
   typedef enum logic [1:0] {
      SW_CENTER = 2'd0,
      SW_UP     = 2'd1,
      SW_DOWN   = 2'd2
   } switch_state_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_CHECK = 2'd1,
      S_EMIT  = 2'd2
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic check;    // evaluate the stored frame
      logic advance;  // result transfer, move to the next channel
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single_result;
      logic last_channel;
   } dp_status_type;

endpackage

// ===== hw/rtl/sfd_req_if.sv =====
// Byte input channel of the SBUS frame decoder.
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_buffer;

   modport source (output valid, output byte_value, output end_of_buffer, input ready);
   modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

// ===== hw/rtl/sfd_rsp_if.sv =====
// Result channel of the SBUS frame decoder.
interface sfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         channel_index;
   logic signed [10:0] channel_value;
   logic [1:0]         switch_state;
   logic [2:0]         status;
   logic               last_result;

   modport source (output valid, output channel_index, output channel_value,
                   output switch_state, output status, output last_result, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input switch_state, input status, input last_result, output ready);
endinterface

// ===== hw/rtl/sfd_ctrl.sv =====
// Controller of the SBUS frame decoder: collect, check and emit sequencing.
module sfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_end,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sfd_pkg::ctrl_cmd_type  cmd,
   input  sfd_pkg::dp_status_type dp_status
);

   sfd_pkg::ctrl_state_type state_ff, state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decide next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.check   = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         sfd_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_end) begin
               state_in = sfd_pkg::S_CHECK;
            end
         end
         sfd_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sfd_pkg::S_EMIT;
         end
         sfd_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (dp_status.single_result || dp_status.last_channel) begin
                  state_in = sfd_pkg::S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = sfd_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sfd_datapath.sv =====
// Datapath of the SBUS frame decoder: frame shift line, header check, channel decode.
module sfd_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [sfd_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [sfd_pkg::CFG_WIDTH-1:0]            csr_write_data,
   input  logic [7:0]                               byte_value,
   input  logic                                     end_of_buffer,
   input  sfd_pkg::ctrl_cmd_type                    cmd,
   output sfd_pkg::dp_status_type                   dp_status,
   output logic [sfd_pkg::CHAN_INDEX_WIDTH-1:0]     channel_index,
   output logic signed [sfd_pkg::CHAN_BITS-1:0]     channel_value,
   output logic [1:0]                               switch_state,
   output logic [2:0]                               status,
   output logic                                     last_result
);

   localparam int unsigned FB = sfd_pkg::FRAME_BITS;
   localparam int unsigned CB = sfd_pkg::CHAN_BITS;

   logic [sfd_pkg::CFG_WIDTH-1:0]        deadband_ff, threshold_ff;
   logic [sfd_pkg::COUNT_WIDTH-1:0]      count_ff, count_in;
   logic                                 short_ff, short_in;
   logic [FB-1:0]                        frame_ff, frame_in;
   sfd_pkg::frame_status_type            status_ff, status_in;
   logic [sfd_pkg::CHAN_INDEX_WIDTH-1:0] chan_ff, chan_in;
   logic                                 has_room;
   logic                                 single;
   logic [CB-1:0]                        raw;
   logic signed [CB:0]                   centered, after_band, db_s, th_s;
   logic                                 in_band;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= sfd_pkg::DEADBAND_RESET;
         threshold_ff <= sfd_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfd_pkg::CSR_DEADBAND:  deadband_ff  <= csr_write_data;
            sfd_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign has_room = (count_ff < sfd_pkg::FRAME_LEN_COUNT);

   // count stored bytes, latch the short flag on the last byte
   always_comb begin
      count_in = count_ff;
      short_in = short_ff;
      if (cmd.accept) begin
         if (end_of_buffer) begin
            count_in = '0;
            short_in = (count_ff < sfd_pkg::SHORT_LIMIT);
         end else if (has_room) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         short_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         short_ff <= short_in;
      end
   end

   // shift bytes in at the top; after 25 bytes byte k sits at bits 8k+7..8k
   // during emission drop one channel field per result from the bottom
   always_comb begin
      frame_in = frame_ff;
      if (cmd.accept && has_room) begin
         frame_in = {byte_value, frame_ff[FB-1:8]};
      end else if (cmd.advance) begin
         frame_in = {{CB{1'b0}}, frame_ff[FB-1:CB]};
      end
   end

   // check the header in priority order
   always_comb begin
      if (short_ff) begin
         status_in = sfd_pkg::ST_SHORT;
      end else if (frame_ff[7:0] != sfd_pkg::START_BYTE) begin
         status_in = sfd_pkg::ST_BAD_START;
      end else if (frame_ff[191:184] != sfd_pkg::FLAGS_OK) begin
         status_in = sfd_pkg::ST_FLAGS;
      end else if (frame_ff[199:192] != sfd_pkg::END_BYTE) begin
         status_in = sfd_pkg::ST_BAD_END;
      end else begin
         status_in = sfd_pkg::ST_OK;
      end
   end

   // advance the channel counter
   always_comb begin
      chan_in = chan_ff;
      if (cmd.check) begin
         chan_in = '0;
      end else if (cmd.advance) begin
         chan_in = chan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      chan_ff  <= chan_in;
      if (cmd.check) begin
         status_ff <= status_in;
      end
   end

   assign single = (status_ff == sfd_pkg::ST_SHORT) || (status_ff == sfd_pkg::ST_BAD_START);
   assign dp_status.single_result = single;
   assign dp_status.last_channel  = (chan_ff == sfd_pkg::LAST_CHANNEL);

   // center the field (minus 1024 flips the top bit), apply deadband and threshold
   assign raw      = frame_ff[8 +: CB];
   assign centered = {{2{~raw[CB-1]}}, raw[CB-2:0]};
   assign db_s     = $signed({2'b00, deadband_ff});
   assign th_s     = $signed({2'b00, threshold_ff});
   assign in_band  = (centered <= db_s) && (centered >= -db_s);
   assign after_band = in_band ? '0 : centered;

   always_comb begin
      if (single) begin
         channel_index = '0;
         channel_value = '0;
         switch_state  = sfd_pkg::SW_CENTER;
         last_result   = 1'b1;
      end else begin
         channel_index = chan_ff;
         channel_value = after_band[CB-1:0];
         if (after_band > th_s) begin
            switch_state = sfd_pkg::SW_DOWN;
         end else if (after_band < -th_s) begin
            switch_state = sfd_pkg::SW_UP;
         end else begin
            switch_state = sfd_pkg::SW_CENTER;
         end
         last_result = (chan_ff == sfd_pkg::LAST_CHANNEL);
      end
   end

   assign status = status_ff;

endmodule

// ===== hw/rtl/sbus_frame_decoder_core.sv =====
// Top level of the SBUS frame decoder: controller and datapath.
//
// Usage:
//   req channel: one received byte per transfer, end_of_buffer set on the
//   last byte of a buffer. The first 25 bytes are kept, later ones dropped.
//   rsp channel: after the last byte, either one result (short buffer or bad
//   start byte) or 16 channel results, the final one with last_result set.
//   csr port: write enable, index (0 deadband, 1 switch threshold), data;
//   write only while no frame is being decoded.
// Timing:
//   Bytes may stream back to back. The last byte is followed by the header
//   check in the S_CHECK state, then results come one per cycle while rsp
//   ready is high, set by the channel sequencer that steps the frame shift
//   line by one 11-bit field per result.
//   req ready is low from the last byte until the final result transfers.
// Reset: clears the byte count, the sequencer and the configuration
// (deadband 10, threshold 500). A stalled receiver holds the current result.
module sbus_frame_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sfd_pkg::CFG_WIDTH-1:0]       csr_write_data,
   sfd_req_if.sink                             req_if,
   sfd_rsp_if.source                           rsp_if
);

   sfd_pkg::ctrl_cmd_type  cmd;
   sfd_pkg::dp_status_type dp_status;

   // sequence the frame
   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_end   (req_if.end_of_buffer),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   // store, check and decode
   sfd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .byte_value       (req_if.byte_value),
      .end_of_buffer    (req_if.end_of_buffer),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .channel_index    (rsp_if.channel_index),
      .channel_value    (rsp_if.channel_value),
      .switch_state     (rsp_if.switch_state),
      .status           (rsp_if.status),
      .last_result      (rsp_if.last_result)
   );

endmodule
